@@ hw/rtl/tch_pkg.sv @@
// ----------------------------------------------------------------------------
// tch_pkg
// Shared types and constants for the terrain characteristic height unit.
// ----------------------------------------------------------------------------
package tch_pkg;

    // Fixed field widths of the transaction payloads and the node count.
    localparam int unsigned IDX_W    = 12;
    localparam int unsigned FIELD_W  = 24;
    localparam int unsigned CNT_W    = 13;

    // Accumulator and divider width.
    localparam int unsigned ACC_W    = 128;
    localparam int unsigned STEP_W   = 8;

    // Divider step counts: weight quotient and final mean.
    localparam logic [STEP_W-1:0] WEIGHT_STEPS = 8'd63;
    localparam logic [STEP_W-1:0] MEAN_STEPS   = 8'd128;

    // Largest reportable height.
    localparam logic [FIELD_W-1:0] HEIGHT_MAX = 24'hFFFFFF;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Input transaction payload.
    typedef struct packed {
        logic                      command;
        logic [IDX_W-1:0]          node_index;
        logic signed [FIELD_W-1:0] x_coord;
        logic signed [FIELD_W-1:0] y_coord;
        logic signed [FIELD_W-1:0] z_coord;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic [IDX_W-1:0]   node_index_out;
        logic [FIELD_W-1:0] char_height;
        logic               degenerate;
    } t_out_item;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RDQ   = 10'b0000000010,
        S_FETCH = 10'b0000000100,
        S_DIFF  = 10'b0000001000,
        S_SQX   = 10'b0000010000,
        S_SQY   = 10'b0000100000,
        S_WCHK  = 10'b0001000000,
        S_WWAIT = 10'b0010000000,
        S_ACC   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

endpackage

@@ hw/rtl/tch_div.sv @@
// ----------------------------------------------------------------------------
// tch_div
// Restoring divider, one quotient bit per cycle, shared by the weight and
// the final mean.
// ----------------------------------------------------------------------------
module tch_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tch_pkg::ACC_W-1:0]     i_num,
    input  logic [tch_pkg::ACC_W-1:0]     i_den,
    input  logic [tch_pkg::STEP_W-1:0]    i_steps,
    output logic                          o_done,
    output logic [tch_pkg::ACC_W-1:0]     o_quot
);
    import tch_pkg::*;

    logic [ACC_W-1:0]  r_rem;
    logic [ACC_W-1:0]  r_num;
    logic [ACC_W-1:0]  r_den;
    logic [ACC_W-1:0]  r_quot;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ACC_W:0]    trial;
    logic              take;

    // Shift the next dividend bit into the remainder and try the subtract.
    always_comb begin
        trial = {r_rem, r_num[ACC_W-1]};
        take  = (trial >= {1'b0, r_den});
    end

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend arrives aligned to its top bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_num  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? ACC_W'(trial - {1'b0, r_den}) : trial[ACC_W-1:0];
            r_num  <= {r_num[ACC_W-2:0], 1'b0};
            r_quot <= {r_quot[ACC_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hw/rtl/terrain_characteristic_height_unit.sv @@
// ----------------------------------------------------------------------------
// terrain_characteristic_height_unit
// Inverse-distance-squared weighted mean of height differences over stored
// ground nodes.
// ----------------------------------------------------------------------------
// A load transaction writes the node's coordinates into three memories. A
// query reads the named node, then walks nodes 0 .. min(node_count,
// MAX_NODES)-1 one at a time through the same memories: each other node
// costs a fetch, the differences and the two squares, and one that is
// neither too far nor coincident also costs a weight division that holds
// the walk in the shared bit-serial divider and an accumulate. The final
// mean then waits for its own division in that divider. The block handles
// one transaction at a time; a finished result waits in the output
// register while the next transaction is accepted.
module terrain_characteristic_height_unit #(
    parameter int MAX_NODES  = 4096,
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tch_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tch_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [tch_pkg::CNT_W-1:0]     i_cfg_wdata
);
    import tch_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int DW = COORD_BITS + 1;

    // Node memories.
    logic signed [COORD_BITS-1:0] mem_x [MAX_NODES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_NODES];
    logic signed [COORD_BITS-1:0] mem_z [MAX_NODES];
    logic signed [COORD_BITS-1:0] r_rdx, r_rdy, r_rdz;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_node_count;
    logic [IDX_W-1:0]     r_q;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_j;
    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_qz;
    logic [DW-1:0]        r_ax, r_ay, r_dh;
    logic [63:0]          r_sqx, r_r2;
    logic [62:0]          r_w;
    logic                 r_far;
    logic                 r_bad;
    logic [ACC_W-1:0]     r_sum_w, r_sum_wd;
    logic                 r_ovalid;
    t_out_item            r_oitem;
    logic                 r_final;
    logic                 r_oob;
    logic [ACC_W-1:0]     r_mean;

    logic                 in_acc;
    logic                 idx_ok;
    logic                 div_start;
    logic [ACC_W-1:0]     div_num, div_den;
    logic [STEP_W-1:0]    div_steps;
    logic                 div_done;
    logic [ACC_W-1:0]     div_quot;
    logic                 out_free;
    logic [DW-1:0]        dx, dy, dz;
    logic [64:0]          prod_lo, prod_hi;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign idx_ok      = (32'(i_in_item.node_index) < 32'(MAX_NODES));
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    // Memory write on a load, read address from the input item while idle, else from the walk counter.
    assign wr_en   = in_acc && (i_in_item.command == CMD_LOAD) && idx_ok;
    assign rd_addr = (r_state == S_IDLE) ? AW'(i_in_item.node_index) : r_j[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[AW'(i_in_item.node_index)] <= COORD_BITS'(i_in_item.x_coord);
            mem_y[AW'(i_in_item.node_index)] <= COORD_BITS'(i_in_item.y_coord);
            mem_z[AW'(i_in_item.node_index)] <= COORD_BITS'(i_in_item.z_coord);
        end
        r_rdx <= mem_x[rd_addr];
        r_rdy <= mem_y[rd_addr];
        r_rdz <= mem_z[rd_addr];
    end

    // Absolute differences against the queried node.
    function automatic logic [DW-1:0] abs_diff(logic signed [COORD_BITS-1:0] a,
                                               logic signed [COORD_BITS-1:0] b);
        logic signed [DW-1:0] d;
        d = DW'(a) - DW'(b);
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    assign dx = abs_diff(r_qx, r_rdx);
    assign dy = abs_diff(r_qy, r_rdy);
    assign dz = abs_diff(r_qz, r_rdz);

    // Weight times height difference, low and high halves of the weight.
    assign prod_lo = {1'b0, r_w[31:0]} * 33'(r_dh);
    assign prod_hi = {2'b0, r_w[62:32]} * 33'(r_dh);

    // Divider operands: weight first, then the final mean.
    always_comb begin
        div_start = 1'b0;
        div_num   = {1'b1, {(ACC_W-1){1'b0}}};
        div_den   = ACC_W'(r_r2);
        div_steps = WEIGHT_STEPS;
        if (r_state == S_WCHK) begin
            div_start = !r_far && (r_r2 != 64'd0);
        end else if (r_state == S_FETCH && 32'(r_j) >= 32'(r_count)) begin
            div_start = !r_bad && (r_sum_w != '0);
            div_num   = r_sum_wd;
            div_den   = r_sum_w;
            div_steps = MEAN_STEPS;
        end
    end

    tch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_item.command == CMD_QUERY) begin
                    n_state = idx_ok ? S_RDQ : S_DONE;
                end
            end
            S_RDQ: n_state = S_FETCH;
            S_FETCH: begin
                if (32'(r_j) >= 32'(r_count)) begin
                    n_state = div_start ? S_WWAIT : S_DONE;
                end else if (32'(r_j) != 32'(r_q)) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_WCHK;
            S_WCHK: n_state = div_start ? S_WWAIT : S_FETCH;
            S_WWAIT: begin
                if (div_done) begin
                    n_state = r_final ? S_DONE : S_ACC;
                end
            end
            S_ACC:  n_state = S_FETCH;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= CNT_W'(1);
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_q      <= i_in_item.node_index;
                r_oob    <= !idx_ok;
                r_j      <= '0;
                r_bad    <= 1'b0;
                r_final  <= 1'b0;
                r_sum_w  <= '0;
                r_sum_wd <= '0;
                r_count  <= (32'(r_node_count) > 32'(MAX_NODES)) ?
                            CW'(MAX_NODES) : CW'(r_node_count);
            end
            S_RDQ: begin
                r_qx <= r_rdx;
                r_qy <= r_rdy;
                r_qz <= r_rdz;
            end
            S_FETCH: begin
                if (32'(r_j) >= 32'(r_count)) begin
                    r_final <= 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            S_DIFF: begin
                r_ax  <= dx;
                r_ay  <= dy;
                r_dh  <= dz;
                r_far <= (34'(dx) > 34'h080000000) || (34'(dy) > 34'h080000000);
            end
            S_SQX: r_sqx <= 32'(r_ax) * 32'(r_ax);
            S_SQY: r_r2  <= r_sqx + 32'(r_ay) * 32'(r_ay);
            S_WCHK: begin
                // A coincident node spoils the whole query.
                if (!r_far && r_r2 == 64'd0) begin
                    r_bad <= 1'b1;
                end
            end
            S_WWAIT: begin
                if (div_done) begin
                    r_w <= div_quot[62:0];
                end
            end
            S_ACC: begin
                r_sum_w  <= r_sum_w + ACC_W'(r_w);
                r_sum_wd <= r_sum_wd + ACC_W'(prod_lo) + (ACC_W'(prod_hi) << 32);
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // Result register, loaded when the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_oitem.node_index_out <= r_q;
            if (r_oob || r_bad || r_sum_w == '0) begin
                r_oitem.char_height <= '0;
                r_oitem.degenerate  <= 1'b1;
            end else begin
                r_oitem.char_height <= (|r_mean[ACC_W-1:FIELD_W]) ?
                                       HEIGHT_MAX : r_mean[FIELD_W-1:0];
                r_oitem.degenerate  <= 1'b0;
            end
        end
    end

    // Final quotient, captured when the mean division finishes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WWAIT && div_done && r_final) begin
            r_mean <= div_quot;
        end
    end

endmodule
